### hdl/mphc_pkg.sv
// Shared types, constants and pattern tables for the multi-pattern hit counter.
// No dependencies.
package mphc_pkg;

    localparam int CHAR_W      = 16;
    localparam int PAT_NUM     = 12;
    localparam int PAT_MAX_LEN = 17;
    localparam int PAT_W       = PAT_MAX_LEN * 8;
    localparam int CNT_W       = 4;

    localparam logic [CHAR_W-1:0] UPPER_FIRST = 16'h0041;
    localparam logic [CHAR_W-1:0] UPPER_LAST  = 16'h005A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 16'h0020;

    typedef struct packed {
        logic load;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic [PAT_NUM-1:0] hit_mask;
        logic [CNT_W-1:0]   hit_count;
        logic               suspicious;
    } result_t;

    // Newest character sits in the lowest byte.
    function automatic logic [PAT_W-1:0] pat_text(input int idx);
        logic [PAT_W-1:0] t;
        case (idx)
            0:       t = " -enc ";
            1:       t = "/enc ";
            2:       t = "encodedcommand";
            3:       t = "frombase64string";
            4:       t = "invoke-expression";
            5:       t = " iex ";
            6:       t = "downloadstring";
            7:       t = "mshta";
            8:       t = "rundll32";
            9:       t = "regsvr32";
            10:      t = "wscript";
            11:      t = "cscript";
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic int pat_len(input int idx);
        int n;
        case (idx)
            0:       n = 6;
            1:       n = 5;
            2:       n = 14;
            3:       n = 16;
            4:       n = 17;
            5:       n = 5;
            6:       n = 14;
            7:       n = 5;
            8:       n = 8;
            9:       n = 8;
            10:      n = 7;
            11:      n = 7;
            default: n = 0;
        endcase
        return n;
    endfunction

endpackage

### hdl/multi_pattern_hit_counter_core.sv
// Multi-pattern hit counter: character window chain, sticky hit mask, result buffer.
// Uses mphc_pkg, mphc_char_cell and mphc_out_buf.
// Throughput: one character per cycle while s_tready is high; window cells shift on every
// transfer but the last, which clears them and pushes the result into the output buffer.
// s_tready falls only while two results wait in the output buffer.
// Reset: window cleared to zero filler, hit mask cleared, hit_threshold set to 2.
module multi_pattern_hit_counter_core
    import mphc_pkg::*;
#(
    parameter int WINDOW_LEN    = 17,
    parameter int PATTERN_COUNT = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CNT_W-1:0]  cfg_wr_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,   // [15:0] char_code
    input  logic              s_tlast,   // last_char
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata    // [0] suspicious, [4:1] hit_count, [16:5] hit_mask
);

    logic [CNT_W-1:0]   threshold_reg;
    logic [PAT_NUM-1:0] sticky_reg;
    logic [PAT_NUM-1:0] sticky_next;
    logic               transfer;
    logic               buf_full;
    logic [CHAR_W-1:0]  char_fold;
    cell_ctrl_t         ctrl;
    logic [CHAR_W-1:0]  win_q   [WINDOW_LEN];
    logic [PAT_NUM-1:0] win_m   [WINDOW_LEN];
    logic [PAT_NUM-1:0] hits_now;
    logic [PAT_NUM-1:0] mask_all;
    logic [CNT_W-1:0]   count;
    logic [1:0]         grp_cnt [4];
    result_t            res;
    result_t            res_out;
    logic               buf_valid;

    assign transfer   = s_tvalid && s_tready;
    assign s_tready   = !buf_full;
    assign ctrl.load  = transfer;
    assign ctrl.clear = transfer && s_tlast;

    assign char_fold = (s_tdata >= UPPER_FIRST && s_tdata <= UPPER_LAST) ?
                       (s_tdata + CASE_OFFSET) : s_tdata;

    for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_cell
        mphc_char_cell #(
            .POS(k)
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .ctrl   (ctrl),
            .din    ((k == 0) ? char_fold : win_q[(k == 0) ? 0 : k - 1]),
            .dout   (win_q[k]),
            .match  (win_m[k])
        );
    end

    always_comb begin
        hits_now = '1;
        for (int k = 0; k < WINDOW_LEN; k++) begin
            hits_now = hits_now & win_m[k];
        end
        for (int i = 0; i < PAT_NUM; i++) begin
            if (i >= PATTERN_COUNT) begin
                hits_now[i] = 1'b0;
            end
        end
    end

    assign mask_all = sticky_reg | hits_now;

    always_comb begin
        for (int g = 0; g < 4; g++) begin
            grp_cnt[g] = {1'b0, mask_all[3*g]} + {1'b0, mask_all[3*g+1]}
                       + {1'b0, mask_all[3*g+2]};
        end
        count = {2'b00, grp_cnt[0]} + {2'b00, grp_cnt[1]}
              + {2'b00, grp_cnt[2]} + {2'b00, grp_cnt[3]};
    end

    always_comb begin
        res.hit_mask   = mask_all;
        res.hit_count  = count;
        res.suspicious = (count >= threshold_reg);
    end

    always_comb begin
        sticky_next = sticky_reg;
        if (transfer) begin
            sticky_next = s_tlast ? '0 : mask_all;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sticky_reg    <= '0;
            threshold_reg <= 4'd2;
        end else begin
            sticky_reg <= sticky_next;
            if (cfg_wr_en) begin
                threshold_reg <= cfg_wr_data;
            end
        end
    end

    mphc_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (ctrl.clear),
        .din      (res),
        .full     (buf_full),
        .pop_ready(m_tready),
        .out_valid(buf_valid),
        .dout     (res_out)
    );

    assign m_tvalid = buf_valid;
    assign m_tdata  = {7'b0000000, res_out};

endmodule

### hdl/mphc_char_cell.sv
// One window position: holds a character, passes it to the next cell and
// compares the incoming character against every pattern at this position. Uses mphc_pkg.
module mphc_char_cell
    import mphc_pkg::*;
#(
    parameter int POS = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cell_ctrl_t         ctrl,
    input  logic [CHAR_W-1:0]  din,
    output logic [CHAR_W-1:0]  dout,
    output logic [PAT_NUM-1:0] match
);

    localparam int BYTE_POS = (POS < PAT_MAX_LEN) ? POS : 0;

    logic [CHAR_W-1:0] char_reg;
    logic [CHAR_W-1:0] char_next;

    always_comb begin
        char_next = char_reg;
        if (ctrl.clear) begin
            char_next = '0;
        end else if (ctrl.load) begin
            char_next = din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_reg <= '0;
        end else begin
            char_reg <= char_next;
        end
    end

    always_comb begin
        logic [PAT_W-1:0] txt;
        for (int i = 0; i < PAT_NUM; i++) begin
            txt = pat_text(i);
            if (POS >= pat_len(i)) begin
                match[i] = 1'b1;
            end else begin
                match[i] = (din == {8'h00, txt[BYTE_POS*8 +: 8]});
            end
        end
    end

    assign dout = char_reg;

endmodule

### hdl/mphc_out_buf.sv
// Two-entry result buffer: output register plus skid register.
// Uses mphc_pkg.
module mphc_out_buf
    import mphc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t din,
    output logic    full,
    input  logic    pop_ready,
    output logic    out_valid,
    output result_t dout
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    take;

    assign take = out_valid_reg && pop_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (take) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || take) begin
                out_valid_next = 1'b1;
                out_data_next  = din;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = din;
            end
        end else if (take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign dout      = out_data_reg;

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !skid_valid_reg)
        else $error("result pushed into full buffer");

    a_stall_fills_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !pop_ready && push) |=> skid_valid_reg)
        else $error("stalled result lost");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && pop_ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry not moved to output");

endmodule
